// ===== src/top_key_retention_cache_assert.svh =====
// assertion macros of the key retention cache checker
`ifndef TOP_KEY_RETENTION_CACHE_ASSERT_SVH
`define TOP_KEY_RETENTION_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TKRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key retention cache check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TKRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key retention cache check failed");

`endif

// ===== src/tkrc_pkg.sv =====
// types and constants of the key retention cache
`timescale 1ns / 1ps

package tkrc_pkg;

  // field widths and defaults
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned CAP_BITS    = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  // slot numbers carried in status structs, wide enough for 256 entries
  localparam int unsigned SLOT_W      = 8;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FILL_ADDED    = 2'd0,
    FILL_REPLACED = 2'd1,
    FILL_DROPPED  = 2'd2,
    FILL_PRESENT  = 2'd3
  } fill_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e                    operation;
    logic [KEY_BITS-1:0]    key_id;
    logic [HANDLE_BITS-1:0] fill_handle;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic [HANDLE_BITS-1:0] handle_out;
    fill_action_e           fill_action;
    logic [KEY_BITS-1:0]    evicted_key;
  } res_t;

  // one entry read back from the store
  typedef struct packed {
    logic                   vld;
    logic [SLOT_W-1:0]      slot;
    logic                   valid;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } rd_t;

  // running scan results of the compare unit
  typedef struct packed {
    logic                   found;
    logic [HANDLE_BITS-1:0] found_handle;
    logic                   min_ok;
    logic [SLOT_W-1:0]      min_slot;
    logic [KEY_BITS-1:0]    min_key;
    logic                   free_ok;
    logic [SLOT_W-1:0]      free_slot;
  } scan_t;

endpackage

// ===== src/tkrc_store.sv =====
// entry store: key and handle memory with valid flags
`timescale 1ns / 1ps

module tkrc_store #(
  parameter int unsigned ENTRIES = tkrc_pkg::ENTRIES,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [IDX_W-1:0]                 rd_addr_i,
  output tkrc_pkg::rd_t                    rd_o,
  input  logic                             wr_en_i,
  input  logic [IDX_W-1:0]                 wr_addr_i,
  input  logic [tkrc_pkg::KEY_BITS-1:0]    wr_key_i,
  input  logic [tkrc_pkg::HANDLE_BITS-1:0] wr_handle_i
);

  localparam int unsigned WORD_W = tkrc_pkg::KEY_BITS + tkrc_pkg::HANDLE_BITS;

  logic [WORD_W-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0]     valid_q;
  logic [WORD_W-1:0]      word_q;
  logic                   rd_vld_q;
  logic                   rd_valid_q;
  logic [IDX_W-1:0]       rd_idx_q;

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_key_i, wr_handle_i};
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      word_q     <= mem[rd_addr_i];
      rd_idx_q   <= rd_addr_i;
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // valid flags, cleared by reset, set on every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en_i;
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_o.vld    = rd_vld_q;
  assign rd_o.slot   = tkrc_pkg::SLOT_W'(rd_idx_q);
  assign rd_o.valid  = rd_valid_q;
  assign rd_o.key    = word_q[WORD_W-1:tkrc_pkg::HANDLE_BITS];
  assign rd_o.handle = word_q[tkrc_pkg::HANDLE_BITS-1:0];

endmodule

// ===== src/tkrc_cmp.sv =====
// shared compare unit: match, minimum and free slot over the scan
`timescale 1ns / 1ps

module tkrc_cmp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic [tkrc_pkg::KEY_BITS-1:0] key_i,
  input  tkrc_pkg::rd_t                 rd_i,
  output tkrc_pkg::scan_t               scan_o
);

  tkrc_pkg::scan_t scan_q, scan_d;
  logic            key_eq;
  logic            key_lt;

  // the one comparator pair, fed one entry per cycle
  assign key_eq = (rd_i.key == key_i);
  assign key_lt = (rd_i.key < scan_q.min_key);

  // fold the current entry into the running result
  always_comb begin
    scan_d = scan_q;
    if (clr_i) begin
      scan_d.found   = 1'b0;
      scan_d.min_ok  = 1'b0;
      scan_d.free_ok = 1'b0;
    end else if (rd_i.vld) begin
      if (rd_i.valid) begin
        // first matching entry wins
        if (key_eq && !scan_q.found) begin
          scan_d.found        = 1'b1;
          scan_d.found_handle = rd_i.handle;
        end
        // strictly smaller key replaces, so ties keep the lowest slot
        if (!scan_q.min_ok || key_lt) begin
          scan_d.min_ok   = 1'b1;
          scan_d.min_slot = rd_i.slot;
          scan_d.min_key  = rd_i.key;
        end
      end else if (!scan_q.free_ok) begin
        scan_d.free_ok   = 1'b1;
        scan_d.free_slot = rd_i.slot;
      end
    end
  end

  // running scan register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

// ===== src/top_key_retention_cache.sv =====
// top level of the key retention cache: sequencer, config and result register
//
//   channel   signals                     transfer when
//   --------  --------------------------  ---------------------
//   request   start, busy, req_i          start high, busy low
//   result    done_o, res_o               done_o high (one cycle)
//   config    cfg_we_i, cfg_wdata_i       cfg_we_i high
//
// busy is high from the accepting edge through the scan, drain and write-back states:
// one read a cycle into the shared compare unit, then a drain state and the write-back.
// done_o pulses in the next cycle with busy low; no new item is taken while busy is high.
// reset clears the valid flags and the count, and capacity returns to 16.
// done_o lasts one cycle and res_o holds until the next result; the receiver cannot stall.
`timescale 1ns / 1ps

module top_key_retention_cache #(
  parameter int unsigned ENTRIES = tkrc_pkg::ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tkrc_pkg::req_t                req_i,
  output logic                          done_o,
  output tkrc_pkg::res_t                res_o,
  input  logic                          cfg_we_i,
  input  logic [tkrc_pkg::CAP_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > tkrc_pkg::CAP_BITS) ? CNT_W : tkrc_pkg::CAP_BITS;

  tkrc_pkg::state_e              state_q, state_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [tkrc_pkg::CAP_BITS-1:0] cap_q;
  tkrc_pkg::req_t                req_q;
  tkrc_pkg::res_t                res_q, res_d;
  logic                          done_q, done_d;

  logic                          accept;
  logic                          rd_en;
  logic                          cmp_clr;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [CMP_W-1:0]              cap_eff;
  logic                          room;
  tkrc_pkg::rd_t                 rd;
  tkrc_pkg::scan_t               scan;

  assign accept = start && !busy;

  // capacity saturated to the table size
  assign cap_eff = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
  assign room    = (CMP_W'(cnt_q) < cap_eff) && scan.free_ok;

  tkrc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_i   (idx_q),
    .rd_o        (rd),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_key_i    (req_q.key_id),
    .wr_handle_i (req_q.fill_handle)
  );

  tkrc_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (cmp_clr),
    .key_i  (req_q.key_id),
    .rd_i   (rd),
    .scan_o (scan)
  );

  // sequencer: scan, drain, decide
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    rd_en   = 1'b0;
    cmp_clr = 1'b0;
    wr_en   = 1'b0;
    wr_addr = scan.free_slot[IDX_W-1:0];
    unique case (state_q)
      tkrc_pkg::ST_IDLE: begin
        if (start) begin
          cmp_clr = 1'b1;
          idx_d   = '0;
          state_d = tkrc_pkg::ST_SCAN;
        end
      end
      tkrc_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(ENTRIES - 1)) begin
          idx_d   = '0;
          state_d = tkrc_pkg::ST_DRAIN;
        end
      end
      tkrc_pkg::ST_DRAIN: begin
        state_d = tkrc_pkg::ST_FINISH;
      end
      tkrc_pkg::ST_FINISH: begin
        done_d            = 1'b1;
        state_d           = tkrc_pkg::ST_IDLE;
        res_d.hit         = 1'b0;
        res_d.handle_out  = '0;
        res_d.fill_action = tkrc_pkg::FILL_ADDED;
        res_d.evicted_key = '0;
        if (req_q.operation == tkrc_pkg::OP_LOOKUP) begin
          if (scan.found) begin
            res_d.hit        = 1'b1;
            res_d.handle_out = scan.found_handle;
          end
        end else if (scan.found) begin
          res_d.fill_action = tkrc_pkg::FILL_PRESENT;
        end else if (room) begin
          // add into the lowest free slot
          wr_en             = 1'b1;
          cnt_d             = cnt_q + CNT_W'(1);
          res_d.fill_action = tkrc_pkg::FILL_ADDED;
        end else if (scan.min_ok && (scan.min_key < req_q.key_id)) begin
          // replace the smallest key
          wr_en             = 1'b1;
          wr_addr           = scan.min_slot[IDX_W-1:0];
          res_d.fill_action = tkrc_pkg::FILL_REPLACED;
          res_d.evicted_key = scan.min_key;
        end else begin
          res_d.fill_action = tkrc_pkg::FILL_DROPPED;
        end
      end
      default: begin
        state_d = tkrc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkrc_pkg::ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      cap_q   <= tkrc_pkg::CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  assign busy   = (state_q != tkrc_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/tkrc_checker.sv =====
// port-level checks of the key retention cache, bound to the top level
`timescale 1ns / 1ps
`include "top_key_retention_cache_assert.svh"

module tkrc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input tkrc_pkg::res_t res_o
);

  // a result only appears once the sequencer is back to idle
  `TKRC_ASSERT_IMP(a_done_idle, done_o, !busy)
  // an accepted item keeps the block busy in the next cycle
  `TKRC_ASSERT_NXT(a_start_busy, start && !busy, busy)
  // every result closes a busy period
  `TKRC_ASSERT_IMP(a_done_after_busy, done_o, $past(busy))
  // a lookup hit carries a zero fill part
  `TKRC_ASSERT_IMP(a_hit_clean, done_o && res_o.hit,
                   res_o.fill_action == tkrc_pkg::FILL_ADDED && res_o.evicted_key == '0)
  // an evicted key shows only on a replacement
  `TKRC_ASSERT_IMP(a_evict_clean, done_o && res_o.fill_action != tkrc_pkg::FILL_REPLACED,
                   res_o.evicted_key == '0)

endmodule

bind top_key_retention_cache tkrc_checker u_tkrc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

// ===== test/tb_top_key_retention_cache.sv =====
// testbench of the key retention cache: directed and random lookups and fills, scoreboard check
`timescale 1ns / 1ps

module tb_top_key_retention_cache;
  import tkrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 100;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  req_t                req_i       = '0;
  logic                done_o;
  res_t                res_o;
  logic                cfg_we_i    = 1'b0;
  logic [CAP_BITS-1:0] cfg_wdata_i = '0;

  int unsigned cycle_count = 0;

  // scoreboard: shadow copy of the cache, queue of predicted results
  class cache_scoreboard;
    logic [KEY_BITS-1:0]    key_tab[ENTRIES];
    logic [HANDLE_BITS-1:0] handle_tab[ENTRIES];
    bit                     valid_tab[ENTRIES];
    int unsigned            live_count;
    logic [CAP_BITS-1:0]    capacity;
    res_t                   pending_res_q[$];
    int unsigned            fail_count;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        key_tab[i]    = '0;
        handle_tab[i] = '0;
        valid_tab[i]  = 1'b0;
      end
      live_count = 0;
      capacity   = CAP_RESET;
      fail_count = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return pending_res_q.size();
    endfunction

    function bit holds_key(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
        if (valid_tab[i] && key_tab[i] == k) return 1'b1;
      return 1'b0;
    endfunction

    // random key currently in the table, if there is one
    function bit stored_key(output logic [KEY_BITS-1:0] k);
      int idx[$];
      for (int i = 0; i < ENTRIES; i++)
        if (valid_tab[i]) idx.push_back(i);
      k = '0;
      if (idx.size() == 0) return 1'b0;
      k = key_tab[idx[$urandom_range(0, idx.size() - 1)]];
      return 1'b1;
    endfunction

    // accepted transfer: scan the table, apply the fill, queue the outcome
    function void note_request(req_t r);
      res_t        want;
      int          found;
      int          free_slot;
      int          min_slot;
      int unsigned cap;
      want      = '0;
      found     = -1;
      free_slot = -1;
      min_slot  = -1;
      cap       = (capacity > ENTRIES) ? ENTRIES : capacity;
      want.fill_action = FILL_ADDED;
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_tab[i]) begin
          if (key_tab[i] == r.key_id && found < 0) found = i;
          if (min_slot < 0 || key_tab[i] < key_tab[min_slot]) min_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (r.operation == OP_LOOKUP) begin
        if (found >= 0) begin
          want.hit        = 1'b1;
          want.handle_out = handle_tab[found];
        end
      end else if (found >= 0) begin
        want.fill_action = FILL_PRESENT;
      end else if (live_count < cap && free_slot >= 0) begin
        // add goes into the lowest free slot
        key_tab[free_slot]    = r.key_id;
        handle_tab[free_slot] = r.fill_handle;
        valid_tab[free_slot]  = 1'b1;
        live_count++;
      end else if (min_slot >= 0 && key_tab[min_slot] < r.key_id) begin
        // smallest stored key gives way to a larger one
        want.fill_action     = FILL_REPLACED;
        want.evicted_key     = key_tab[min_slot];
        key_tab[min_slot]    = r.key_id;
        handle_tab[min_slot] = r.fill_handle;
      end else begin
        want.fill_action = FILL_DROPPED;
      end
      pending_res_q.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    // compare a result with the oldest prediction, field by field
    task check_result(res_t got);
      res_t want;
      if (pending_res_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_res_q.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.handle_out !== want.handle_out)
        report($sformatf("handle_out got %h want %h", got.handle_out, want.handle_out));
      if (got.fill_action !== want.fill_action)
        report($sformatf("fill_action got %0d want %0d", got.fill_action, want.fill_action));
      if (got.evicted_key !== want.evicted_key)
        report($sformatf("evicted_key got %h want %h", got.evicted_key, want.evicted_key));
    endtask
  endclass

  cache_scoreboard sb = new();

  top_key_retention_cache uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result monitor, sampled before the edge updates
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  function automatic req_t make_req(op_e op, logic [KEY_BITS-1:0] k,
                                    logic [HANDLE_BITS-1:0] h);
    req_t r;
    r.operation   = op;
    r.key_id      = k;
    r.fill_handle = h;
    return r;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 63);
    if (r < 45) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7fff_ffff;
        3: return 32'h8000_0000;
        4: return 32'hffff_fffe;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 65) return 32'hffff_ff00 | $urandom_range(0, 255);
    return $urandom;
  endfunction

  // start held high until the transfer happens
  task automatic drive_item(input req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // start low, junk on the request bus
  task automatic idle_for(input int unsigned n);
    repeat (n) begin
      start <= 1'b0;
      req_i <= make_req(op_e'($urandom_range(0, 1)), $urandom, $urandom_range(0, 65535));
      @(posedge clk_i);
    end
  endtask

  // one item plus, unless steady, a random gap about 30 percent of the time
  task automatic send(input req_t r, input bit steady);
    drive_item(r);
    if (!steady && $urandom_range(0, 99) < 30) idle_for($urandom_range(1, 40));
  endtask

  // stop issuing and wait until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_capacity(v);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // one random phase of cache traffic: mostly lookup then fill on miss
  task automatic run_phase(input bit steady);
    int unsigned          sent;
    int unsigned          r;
    logic [KEY_BITS-1:0]  k;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = pick_key();
        send(make_req(OP_LOOKUP, k, $urandom_range(0, 65535)), steady);
        sent++;
        if (!sb.holds_key(k) && $urandom_range(0, 99) < 85) begin
          send(make_req(OP_FILL, k, $urandom_range(0, 65535)), steady);
          sent++;
        end
      end else if (r < 75) begin
        if (!sb.stored_key(k)) k = pick_key();
        send(make_req(OP_LOOKUP, k, $urandom_range(0, 65535)), steady);
        sent++;
      end else if (r < 90) begin
        send(make_req(OP_FILL, pick_key(), $urandom_range(0, 65535)), steady);
        sent++;
      end else begin
        if (!sb.stored_key(k)) k = pick_key();
        send(make_req(OP_FILL, k, $urandom_range(0, 65535)), steady);
        sent++;
      end
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] phase_cap[9];
    phase_cap = '{5'd2, 5'd5, 5'd16, 5'd0, 5'd31, 5'd1, 5'd9, 5'd17, 5'd16};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: misses, then a fill with capacity zero is dropped
    send(make_req(OP_LOOKUP, 32'h0000_0000, 16'hffff), 1'b0);
    send(make_req(OP_LOOKUP, 32'hffff_ffff, 16'h0000), 1'b0);
    write_capacity(5'd0);
    send(make_req(OP_FILL, 32'h0000_0005, 16'h1234), 1'b0);
    send(make_req(OP_LOOKUP, 32'h0000_0005, 16'h0000), 1'b0);

    // adds, duplicate fill, hits with extreme keys and handles
    write_capacity(5'd16);
    send(make_req(OP_FILL, 32'h0000_0000, 16'hffff), 1'b0);
    send(make_req(OP_FILL, 32'h0000_0000, 16'h0001), 1'b0);
    send(make_req(OP_LOOKUP, 32'h0000_0000, 16'h5555), 1'b0);
    send(make_req(OP_FILL, 32'hffff_ffff, 16'h0000), 1'b0);
    send(make_req(OP_LOOKUP, 32'hffff_ffff, 16'hffff), 1'b0);

    // full at capacity two: replace smallest, then drop a smaller key
    write_capacity(5'd2);
    send(make_req(OP_FILL, 32'h0000_0005, 16'haaaa), 1'b0);
    send(make_req(OP_FILL, 32'h0000_0001, 16'h5555), 1'b0);
    send(make_req(OP_LOOKUP, 32'h0000_0005, 16'h0000), 1'b0);

    // capacity zero on a non-empty table still replaces
    write_capacity(5'd0);
    send(make_req(OP_FILL, 32'h0000_0006, 16'h0f0f), 1'b0);
    send(make_req(OP_LOOKUP, 32'h0000_0005, 16'h0000), 1'b0);
    send(make_req(OP_FILL, 32'h0000_0002, 16'hf0f0), 1'b0);

    // capacity above the table size saturates
    write_capacity(5'd31);
    send(make_req(OP_FILL, 32'h8000_0000, 16'h8000), 1'b0);
    send(make_req(OP_FILL, 32'h7fff_ffff, 16'h7fff), 1'b0);
    send(make_req(OP_FILL, 32'h0000_0003, 16'h0003), 1'b0);

    // capacity lowered below the valid count
    write_capacity(5'd1);
    send(make_req(OP_FILL, 32'h0000_0004, 16'h0004), 1'b0);
    send(make_req(OP_FILL, 32'h0000_0001, 16'h0001), 1'b0);
    send(make_req(OP_LOOKUP, 32'h0000_0003, 16'h0000), 1'b0);

    // random phases, one of them with no idling
    for (int p = 0; p < 9; p++) begin
      write_capacity(phase_cap[p]);
      run_phase(p == 4);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
